@@ hw/rtl/at2d_pkg.sv @@
// at2d_pkg: shared types, constants and the microcode program of the 2D affine core.
// Used by affine_transform_2d_core; it depends on nothing else.
package at2d_pkg;

  localparam int unsigned UPC_W = 5;
  localparam int unsigned ACC_W = 52;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  typedef enum logic [2:0] {
    OP_IDENTITY  = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_ROTATE    = 3'd3,
    OP_POINT     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_e;

  // coefficient operand
  typedef enum logic [3:0] {
    A_E0, A_E1, A_E3, A_E4, A_K1X, A_K1Y, A_KC, A_S, A_M0, A_M1, A_M3, A_M4
  } asel_e;

  // data operand
  typedef enum logic [3:0] {
    B_M0, B_M1, B_M2, B_M3, B_M4, B_M5, B_RX, B_RY, B_PX, B_PY
  } bsel_e;

  typedef enum logic [2:0] {
    X_NONE, X_E2, X_E5, X_M2, X_M5
  } xsel_e;

  typedef enum logic [3:0] {
    D_NONE, D_E2, D_E5, D_TMP, D_COL0, D_COL1, D_COL2, D_OUTX, D_OUTY
  } dst_e;

  typedef enum logic [1:0] {
    SQ_NEXT, SQ_JUMP, SQ_END, SQ_END_OUT
  } seq_e;

  // what happens to a product in the cycle after it is issued
  typedef struct packed {
    logic  first;
    logic  neg;
    logic  sh;
    xsel_e x;
    dst_e  d;
  } fate_t;

  typedef struct packed {
    asel_e             a;
    bsel_e             b;
    fate_t             f;
    seq_e              sq;
    logic [UPC_W-1:0]  tgt;
  } uword_t;

  localparam fate_t FATE_NOP = '{first: 1'b1, neg: 1'b0, sh: 1'b1, x: X_NONE, d: D_NONE};

  localparam logic [UPC_W-1:0] ENT_ROT = 5'd0;
  localparam logic [UPC_W-1:0] ENT_SCL = 5'd4;
  localparam logic [UPC_W-1:0] ENT_MUL = 5'd6;
  localparam logic [UPC_W-1:0] ENT_PNT = 5'd19;

  function automatic uword_t mk(asel_e a, bsel_e b, logic first, logic neg, logic sh,
                                xsel_e x, dst_e d, seq_e sq, logic [UPC_W-1:0] tgt);
    uword_t w;
    w.a       = a;
    w.b       = b;
    w.f.first = first;
    w.f.neg   = neg;
    w.f.sh    = sh;
    w.f.x     = x;
    w.f.d     = d;
    w.sq      = sq;
    w.tgt     = tgt;
    return w;
  endfunction

  function automatic uword_t ucode(logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      // rotate: third column terms
      5'd0:  w = mk(A_KC,  B_RX, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd1:  w = mk(A_S,   B_RY, 1'b0, 1'b0, 1'b1, X_NONE, D_E2,   SQ_NEXT, '0);
      5'd2:  w = mk(A_KC,  B_RY, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd3:  w = mk(A_S,   B_RX, 1'b0, 1'b1, 1'b1, X_NONE, D_E5,   SQ_JUMP, ENT_MUL);
      // scale: third column terms, exact products
      5'd4:  w = mk(A_K1X, B_RX, 1'b1, 1'b0, 1'b0, X_NONE, D_E2,   SQ_NEXT, '0);
      5'd5:  w = mk(A_K1Y, B_RY, 1'b1, 1'b0, 1'b0, X_NONE, D_E5,   SQ_JUMP, ENT_MUL);
      // pre-multiply, one column at a time
      5'd6:  w = mk(A_E0,  B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd7:  w = mk(A_E1,  B_M3, 1'b0, 1'b0, 1'b1, X_NONE, D_TMP,  SQ_NEXT, '0);
      5'd8:  w = mk(A_E3,  B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd9:  w = mk(A_E4,  B_M3, 1'b0, 1'b0, 1'b1, X_NONE, D_COL0, SQ_NEXT, '0);
      5'd10: w = mk(A_E0,  B_M1, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd11: w = mk(A_E1,  B_M4, 1'b0, 1'b0, 1'b1, X_NONE, D_TMP,  SQ_NEXT, '0);
      5'd12: w = mk(A_E3,  B_M1, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd13: w = mk(A_E4,  B_M4, 1'b0, 1'b0, 1'b1, X_NONE, D_COL1, SQ_NEXT, '0);
      5'd14: w = mk(A_E0,  B_M2, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd15: w = mk(A_E1,  B_M5, 1'b0, 1'b0, 1'b1, X_E2,   D_TMP,  SQ_NEXT, '0);
      5'd16: w = mk(A_E3,  B_M2, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd17: w = mk(A_E4,  B_M5, 1'b0, 1'b0, 1'b1, X_E5,   D_COL2, SQ_NEXT, '0);
      5'd18: w = mk(A_E0,  B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_END,  '0);
      // transform point
      5'd19: w = mk(A_M0,  B_PX, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd20: w = mk(A_M1,  B_PY, 1'b0, 1'b0, 1'b1, X_M2,   D_OUTX, SQ_NEXT, '0);
      5'd21: w = mk(A_M3,  B_PX, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd22: w = mk(A_M4,  B_PY, 1'b0, 1'b0, 1'b1, X_M5,   D_OUTY, SQ_NEXT, '0);
      5'd23: w = mk(A_E0,  B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_NEXT, '0);
      5'd24: w = mk(A_E0,  B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_END_OUT, '0);
      default: w = mk(A_E0, B_M0, 1'b1, 1'b0, 1'b1, X_NONE, D_NONE, SQ_END, '0);
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/affine_transform_2d_core.sv @@
// affine_transform_2d_core: 2D homogeneous affine transform, Q16.16, microcoded.
// Depends on at2d_pkg for types, constants and the control program.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with the operation and its operands.
//   A request is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Identity, translate, scale and rotate update the stored matrix (M := E * M)
//   and return nothing; transform point returns one result on out_valid_o /
//   out_stall_i, taken when out_valid_o is high and out_stall_i low.
//   Unused operation codes are dropped without effect.
// Resources: one shared 32x32 multiplier, one product per step of the program.
//   Identity takes effect on acceptance; translate runs the pre-multiply steps,
//   scale and rotate first form the third column terms and then pre-multiply.
//   A point result is loaded into the output register in the final step of its program.
//   One request is in work at a time; in_stall_o is high while it runs.
// Reset: the matrix returns to identity and both channels go empty.
// Stall: a result waits in the output register while out_stall_i is high; a
//   following point holds in its final step until that register frees up,
//   while matrix requests run on regardless.
module affine_transform_2d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] shift_x_i,
  input  logic signed [15:0] shift_y_i,
  input  logic signed [15:0] factor_x_i,
  input  logic signed [15:0] factor_y_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  input  logic signed [17:0] rot_cos_i,
  input  logic signed [17:0] rot_sin_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               out_last_o,
  output logic               clipped_o
);

  at2d_pkg::st_e                  state_q, state_d;
  logic [at2d_pkg::UPC_W-1:0]     upc_q, upc_d;
  at2d_pkg::uword_t               uw;
  at2d_pkg::fate_t                fate_q, fate_d;
  at2d_pkg::op_e                  op_in;
  logic                           accept;
  logic                           out_load;

  at2d_pkg::op_e                  op_q;
  logic signed [15:0]             fx_q, fy_q;
  logic signed [31:0]             rx_q, ry_q, px_q, py_q;
  logic signed [17:0]             c_q, s_q;
  logic                           last_q;

  logic signed [31:0]             m_q [6];
  logic signed [31:0]             tmp_q;
  logic signed [at2d_pkg::ACC_W-1:0] e2_q, e5_q;
  logic signed [at2d_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [63:0]             prod_q;
  logic signed [31:0]             x_q, y_q;
  logic                           clip_q;

  logic signed [31:0]             a_val, b_val;
  logic signed [31:0]             c32, s32, e0, e1, e3, e4;
  logic signed [63:0]             prod_sh;
  logic signed [at2d_pkg::ACC_W-1:0] term, base, extra;
  logic                           fits;
  logic signed [31:0]             sat;

  logic                           out_valid_q;
  logic signed [31:0]             out_x_q, out_y_q;
  logic                           out_last_q, clipped_q;

  assign op_in      = at2d_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != at2d_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign uw         = at2d_pkg::ucode(upc_q);
  assign out_load   = (state_q == at2d_pkg::ST_RUN) && (uw.sq == at2d_pkg::SQ_END_OUT) &&
                      (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    fate_d  = at2d_pkg::FATE_NOP;
    case (state_q)
      at2d_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_in)
            at2d_pkg::OP_TRANSLATE: begin
              upc_d   = at2d_pkg::ENT_MUL;
              state_d = at2d_pkg::ST_RUN;
            end
            at2d_pkg::OP_SCALE: begin
              upc_d   = at2d_pkg::ENT_SCL;
              state_d = at2d_pkg::ST_RUN;
            end
            at2d_pkg::OP_ROTATE: begin
              upc_d   = at2d_pkg::ENT_ROT;
              state_d = at2d_pkg::ST_RUN;
            end
            at2d_pkg::OP_POINT: begin
              upc_d   = at2d_pkg::ENT_PNT;
              state_d = at2d_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      at2d_pkg::ST_RUN: begin
        fate_d = uw.f;
        case (uw.sq)
          at2d_pkg::SQ_NEXT:    upc_d = upc_q + 5'd1;
          at2d_pkg::SQ_JUMP:    upc_d = uw.tgt;
          at2d_pkg::SQ_END:     state_d = at2d_pkg::ST_IDLE;
          at2d_pkg::SQ_END_OUT: begin
            if (out_load) state_d = at2d_pkg::ST_IDLE;
          end
          default:              state_d = at2d_pkg::ST_IDLE;
        endcase
      end
      default: state_d = at2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= at2d_pkg::ST_IDLE;
      upc_q   <= '0;
      fate_q  <= at2d_pkg::FATE_NOP;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      fate_q  <= fate_d;
    end
  end

  // request operands
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_in;
      fx_q   <= factor_x_i;
      fy_q   <= factor_y_i;
      rx_q   <= ref_x_i;
      ry_q   <= ref_y_i;
      c_q    <= rot_cos_i;
      s_q    <= rot_sin_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      last_q <= last_point_i;
    end
  end

  // elementary matrix, left two columns
  assign c32 = {{14{c_q[17]}}, c_q};
  assign s32 = {{14{s_q[17]}}, s_q};

  always_comb begin
    e0 = at2d_pkg::Q_ONE;
    e1 = '0;
    e3 = '0;
    e4 = at2d_pkg::Q_ONE;
    case (op_q)
      at2d_pkg::OP_SCALE: begin
        e0 = {fx_q, 16'h0000};
        e4 = {fy_q, 16'h0000};
      end
      at2d_pkg::OP_ROTATE: begin
        e0 = c32;
        e1 = 32'sd0 - s32;
        e3 = s32;
        e4 = c32;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (uw.a)
      at2d_pkg::A_E0:  a_val = e0;
      at2d_pkg::A_E1:  a_val = e1;
      at2d_pkg::A_E3:  a_val = e3;
      at2d_pkg::A_E4:  a_val = e4;
      at2d_pkg::A_K1X: a_val = 32'sd1 - {{16{fx_q[15]}}, fx_q};
      at2d_pkg::A_K1Y: a_val = 32'sd1 - {{16{fy_q[15]}}, fy_q};
      at2d_pkg::A_KC:  a_val = at2d_pkg::Q_ONE - c32;
      at2d_pkg::A_S:   a_val = s32;
      at2d_pkg::A_M0:  a_val = m_q[0];
      at2d_pkg::A_M1:  a_val = m_q[1];
      at2d_pkg::A_M3:  a_val = m_q[3];
      at2d_pkg::A_M4:  a_val = m_q[4];
      default:         a_val = '0;
    endcase
  end

  always_comb begin
    case (uw.b)
      at2d_pkg::B_M0: b_val = m_q[0];
      at2d_pkg::B_M1: b_val = m_q[1];
      at2d_pkg::B_M2: b_val = m_q[2];
      at2d_pkg::B_M3: b_val = m_q[3];
      at2d_pkg::B_M4: b_val = m_q[4];
      at2d_pkg::B_M5: b_val = m_q[5];
      at2d_pkg::B_RX: b_val = rx_q;
      at2d_pkg::B_RY: b_val = ry_q;
      at2d_pkg::B_PX: b_val = px_q;
      at2d_pkg::B_PY: b_val = py_q;
      default:        b_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_val * b_val;
  end

  // accumulate: products truncated toward minus infinity
  assign prod_sh = fate_q.sh ? (prod_q >>> 16) : prod_q;
  assign term    = prod_sh[at2d_pkg::ACC_W-1:0];
  assign base    = fate_q.first ? '0 : acc_q;

  always_comb begin
    case (fate_q.x)
      at2d_pkg::X_E2: extra = e2_q;
      at2d_pkg::X_E5: extra = e5_q;
      at2d_pkg::X_M2: extra = {{(at2d_pkg::ACC_W-32){m_q[2][31]}}, m_q[2]};
      at2d_pkg::X_M5: extra = {{(at2d_pkg::ACC_W-32){m_q[5][31]}}, m_q[5]};
      default:        extra = '0;
    endcase
  end

  assign acc_d = base + (fate_q.neg ? -term : term) + extra;
  assign fits  = (&acc_d[at2d_pkg::ACC_W-1:31]) || !(|acc_d[at2d_pkg::ACC_W-1:31]);
  assign sat   = fits ? acc_d[31:0] :
                 (acc_d[at2d_pkg::ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (accept && (op_in == at2d_pkg::OP_TRANSLATE)) begin
      e2_q <= {{20{shift_x_i[15]}}, shift_x_i, 16'h0000};
      e5_q <= {{20{shift_y_i[15]}}, shift_y_i, 16'h0000};
    end else begin
      if (fate_q.d == at2d_pkg::D_E2) e2_q <= acc_d;
      if (fate_q.d == at2d_pkg::D_E5) e5_q <= acc_d;
    end
    case (fate_q.d)
      at2d_pkg::D_TMP:  tmp_q <= sat;
      at2d_pkg::D_OUTX: begin
        x_q    <= sat;
        clip_q <= !fits;
      end
      at2d_pkg::D_OUTY: begin
        y_q    <= sat;
        clip_q <= clip_q || !fits;
      end
      default: ;
    endcase
  end

  // composite matrix; a column is committed once both rows are done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q[0] <= at2d_pkg::Q_ONE;
      m_q[1] <= '0;
      m_q[2] <= '0;
      m_q[3] <= '0;
      m_q[4] <= at2d_pkg::Q_ONE;
      m_q[5] <= '0;
    end else if (accept && (op_in == at2d_pkg::OP_IDENTITY)) begin
      m_q[0] <= at2d_pkg::Q_ONE;
      m_q[1] <= '0;
      m_q[2] <= '0;
      m_q[3] <= '0;
      m_q[4] <= at2d_pkg::Q_ONE;
      m_q[5] <= '0;
    end else begin
      case (fate_q.d)
        at2d_pkg::D_COL0: begin
          m_q[0] <= tmp_q;
          m_q[3] <= sat;
        end
        at2d_pkg::D_COL1: begin
          m_q[1] <= tmp_q;
          m_q[4] <= sat;
        end
        at2d_pkg::D_COL2: begin
          m_q[2] <= tmp_q;
          m_q[5] <= sat;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_last_q <= last_q;
      clipped_q  <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;
  assign clipped_o   = clipped_q;

endmodule
